// File: rtl/core/crcph_pkg.sv
// ----------------------------------------------------------------------------
// crcph_pkg
// Types, constants and the table function of the prefix-loaded CRC-32 hash.
// ----------------------------------------------------------------------------
package crcph_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 3;

  localparam logic [HashW-1:0] PolyReset  = 32'h04C1_1DB7;
  localparam logic [PosW-1:0]  PosPacked  = 3'd4;

  typedef struct packed {
    logic             produce;
    logic [HashW-1:0] hash;
  } crcph_result_t;

  // Table entry for one top byte: eight MSB-first shift and conditional XOR steps.
  function automatic logic [HashW-1:0] crcph_table(input logic [ByteW-1:0] top,
                                                    input logic [HashW-1:0] poly);
    logic [HashW-1:0] v;
    v = {top, {(HashW-ByteW){1'b0}}};
    for (int k = 0; k < 8; k++) begin
      v = v[HashW-1] ? ({v[HashW-2:0], 1'b0} ^ poly) : {v[HashW-2:0], 1'b0};
    end
    return v;
  endfunction

endpackage

// File: rtl/core/crcph_core.sv
// ----------------------------------------------------------------------------
// crcph_core
// Hash state and the one-beat update of the accumulator.
// ----------------------------------------------------------------------------
module crcph_core import crcph_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [ByteW-1:0] data_byte,
  input  logic             last_byte,
  input  logic             empty_message,
  input  logic [HashW-1:0] polynomial,
  output crcph_result_t    result
);

  logic [HashW-1:0] acc_r, acc_nxt, acc_upd;
  logic [PosW-1:0]  pos_r, pos_nxt, pos_upd;
  logic             term_r, term_nxt, term_upd;
  logic [HashW-1:0] packed_byte;

  always_comb begin
    case (pos_r)
      3'd1:    packed_byte = {8'h00, data_byte, 16'h0000};
      3'd2:    packed_byte = {16'h0000, data_byte, 8'h00};
      3'd3:    packed_byte = {24'h000000, data_byte};
      default: packed_byte = '0;
    endcase
  end

  always_comb begin
    acc_upd  = acc_r;
    pos_upd  = pos_r;
    term_upd = term_r;
    if (!term_r) begin
      if (pos_r == 3'd0) begin
        acc_upd = {data_byte, 24'h000000};
        pos_upd = 3'd1;
      end else if (data_byte == '0) begin
        term_upd = 1'b1;
      end else if (pos_r < PosPacked) begin
        pos_upd = pos_r + 3'd1;
        acc_upd = (pos_r == 3'd3) ? ~(acc_r | packed_byte) : (acc_r | packed_byte);
      end else begin
        acc_upd = {acc_r[HashW-ByteW-1:0], data_byte}
                  ^ crcph_table(acc_r[HashW-1 -: ByteW], polynomial);
      end
    end
  end

  always_comb begin
    result.produce = empty_message || last_byte;
    if (empty_message) begin
      result.hash = '0;
    end else begin
      result.hash = (pos_upd >= PosPacked) ? ~acc_upd : acc_upd;
    end
    if (result.produce) begin
      acc_nxt  = '0;
      pos_nxt  = '0;
      term_nxt = 1'b0;
    end else begin
      acc_nxt  = acc_upd;
      pos_nxt  = pos_upd;
      term_nxt = term_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pos_r  <= '0;
      term_r <= 1'b0;
    end else if (step) begin
      acc_r  <= acc_nxt;
      pos_r  <= pos_nxt;
      term_r <= term_nxt;
    end
  end

endmodule

// File: rtl/core/crc32_prefix_loaded_string_hash_top.sv
// ----------------------------------------------------------------------------
// crc32_prefix_loaded_string_hash_top
// Byte-serial string hash with a prefix-loaded, MSB-first CRC-32 update.
// ----------------------------------------------------------------------------
// Each beat is held in an input register and then folded into the hash
// state, so the block takes one byte per clock unless stalled; a beat that
// ends a string writes its hash from the input register into the output
// register. The only stall comes from the output register, when a
// finished hash is still waiting and the held beat would produce another.
module crc32_prefix_loaded_string_hash_top import crcph_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_data_byte,
  input  logic             in_last_byte,
  input  logic             in_empty_message,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [HashW-1:0] out_hash_value,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic             in_valid_r;
  logic [ByteW-1:0] data_r;
  logic             last_r;
  logic             empty_r;
  logic             out_valid_r;
  logic [HashW-1:0] hash_r;
  logic [HashW-1:0] poly_r;
  logic             step;
  logic             out_free;
  crcph_result_t    result;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'h0 : poly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= PolyReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      poly_r <= cfg_pwdata;
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign step     = in_valid_r && (!result.produce || out_free);
  assign in_ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r  <= in_data_byte;
      last_r  <= in_last_byte;
      empty_r <= in_empty_message;
    end
  end

  crcph_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .data_byte     (data_r),
    .last_byte     (last_r),
    .empty_message (empty_r),
    .polynomial    (poly_r),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && result.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.produce) begin
      hash_r <= result.hash;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_r;

endmodule

// File: rtl/core/crcph_checker.sv
// ----------------------------------------------------------------------------
// crcph_checker
// Port-level checks of the string hash, bound to its top level.
// ----------------------------------------------------------------------------
module crcph_checker import crcph_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [HashW-1:0] out_hash_value,
  input logic             cfg_psel,
  input logic             cfg_penable,
  input logic             cfg_pwrite,
  input logic [2:0]       cfg_paddr,
  input logic [31:0]      cfg_pwdata,
  input logic [31:0]      cfg_prdata,
  input logic             cfg_pready
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result beat shown right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash_value))
    else $error("Stalled result beat changed or vanished.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input stalled without a waiting result beat.");

  a_poly_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2])
    && cfg_psel && !cfg_pwrite && !cfg_paddr[2] |-> cfg_prdata == $past(cfg_pwdata))
    else $error("Polynomial read does not return the last write.");

endmodule

bind crc32_prefix_loaded_string_hash_top crcph_checker u_crcph_checker (.*);
